>>> src/delta_row_rle_bitmap_decoder_assert.svh
// Assertion helpers for the bitmap decoder; clk and arst_n are taken from the scope of use.
`ifndef DELTA_ROW_RLE_BITMAP_DECODER_ASSERT_SVH
`define DELTA_ROW_RLE_BITMAP_DECODER_ASSERT_SVH

// same-cycle implication
`define DRBD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("drbd: property failed");

// next-cycle implication
`define DRBD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("drbd: property failed");

`endif

>>> src/drbd_pkg.sv
package drbd_pkg;

	localparam int MAX_ROW_WORDS_DEF = 64;
	localparam int QUEUE_DEPTH       = 4;

	typedef enum logic [2:0] {
		PH_H0,
		PH_H1,
		PH_W0,
		PH_W1,
		PH_COUNT,
		PH_LOW,
		PH_HIGH
	} phase_t;

	typedef enum logic [1:0] {
		CMD_WORD,
		CMD_HDR,
		CMD_ERR
	} cmd_kind_t;

	typedef enum logic [1:0] {
		RES_PIXELS = 2'd0,
		RES_HEADER = 2'd1,
		RES_ERROR  = 2'd2
	} res_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_ZERO_COUNT = 2'd1,
		ERR_OVERRUN    = 2'd2,
		ERR_WIDTH      = 2'd3
	} err_code_t;

	// One classified command. WORD: data_a word, count repeats.
	// HDR: data_a height, data_b width in words. ERR: data_a row, column.
	typedef struct packed {
		cmd_kind_t   kind;
		logic [15:0] data_a;
		logic [15:0] data_b;
		logic [6:0]  count;
		logic [5:0]  column;
		err_code_t   err_code;
		logic        empty_img;
	} cmd_t;

endpackage

>>> src/drbd_front.sv
module drbd_front #(
	parameter int MAX_ROW_WORDS = drbd_pkg::MAX_ROW_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           byte_valid,
	output logic           byte_ready,
	input  logic [7:0]     stream_byte,
	input  logic           q_full,
	output logic           q_push,
	output drbd_pkg::cmd_t q_data
);
	import drbd_pkg::*;

	localparam int COL_W = $clog2(MAX_ROW_WORDS + 1);
	localparam int CMP_W = (COL_W > 7) ? COL_W : 7;

	phase_t             phase_q, phase_d;
	logic [15:0]        height_q, height_d;
	logic [COL_W-1:0]   rw_q, rw_d;
	logic [15:0]        row_q, row_d;
	logic [COL_W-1:0]   col_q, col_d;
	logic [6:0]         rem_q, rem_d;
	logic               run_q, run_d;
	logic [7:0]         low_q, low_d;
	logic               stop_q, stop_d;

	logic               accept;
	logic [15:0]        w16;
	logic [15:0]        wwords;
	logic [COL_W-1:0]   adv;
	logic [COL_W-1:0]   ncol;
	logic               empty;

	assign byte_ready = !q_full;
	assign accept     = byte_valid && !q_full;

	always_comb begin
		phase_d  = phase_q;
		height_d = height_q;
		rw_d     = rw_q;
		row_d    = row_q;
		col_d    = col_q;
		rem_d    = rem_q;
		run_d    = run_q;
		low_d    = low_q;
		stop_d   = stop_q;
		q_push   = 1'b0;
		q_data   = '0;
		w16      = {stream_byte, low_q};
		// pixel widths round up to whole 16-bit words
		wwords   = w16[15] ? ((16'(w16[14:0]) + 16'd15) >> 4) : w16;
		empty    = (height_q == 16'd0) || (wwords == 16'd0);
		adv      = run_q ? COL_W'(rem_q) : COL_W'(1);
		ncol     = col_q + adv;
		if (accept && !stop_q) begin
			case (phase_q)
				PH_H0: begin
					height_d[7:0] = stream_byte;
					phase_d = PH_H1;
				end
				PH_H1: begin
					height_d[15:8] = stream_byte;
					phase_d = PH_W0;
				end
				PH_W0: begin
					low_d = stream_byte;
					phase_d = PH_W1;
				end
				PH_W1: begin
					q_push = 1'b1;
					if (wwords > 16'(MAX_ROW_WORDS)) begin
						q_data.kind     = CMD_ERR;
						q_data.data_a   = row_q;
						q_data.column   = 6'(col_q);
						q_data.err_code = ERR_WIDTH;
						stop_d  = 1'b1;
						phase_d = PH_H0;
					end else begin
						q_data.kind      = CMD_HDR;
						q_data.data_a    = height_q;
						q_data.data_b    = wwords;
						q_data.empty_img = empty;
						rw_d    = COL_W'(wwords);
						row_d   = '0;
						col_d   = '0;
						rem_d   = '0;
						run_d   = 1'b0;
						phase_d = empty ? PH_H0 : PH_COUNT;
					end
				end
				PH_COUNT: begin
					run_d = stream_byte[7];
					rem_d = stream_byte[6:0];
					if (stream_byte[6:0] == 7'd0) begin
						q_push          = 1'b1;
						q_data.kind     = CMD_ERR;
						q_data.data_a   = row_q;
						q_data.column   = 6'(col_q);
						q_data.err_code = ERR_ZERO_COUNT;
						stop_d = 1'b1;
					end else if (CMP_W'(stream_byte[6:0]) > CMP_W'(rw_q - col_q)) begin
						q_push          = 1'b1;
						q_data.kind     = CMD_ERR;
						q_data.data_a   = row_q;
						q_data.column   = 6'(col_q);
						q_data.err_code = ERR_OVERRUN;
						stop_d = 1'b1;
					end else begin
						phase_d = PH_LOW;
					end
				end
				PH_LOW: begin
					low_d = stream_byte;
					phase_d = PH_HIGH;
				end
				PH_HIGH: begin
					q_push        = 1'b1;
					q_data.kind   = CMD_WORD;
					q_data.data_a = w16;
					q_data.count  = run_q ? rem_q : 7'd1;
					if (run_q) begin
						rem_d   = '0;
						phase_d = PH_COUNT;
					end else begin
						rem_d   = rem_q - 7'd1;
						phase_d = (rem_q > 7'd1) ? PH_LOW : PH_COUNT;
					end
					// packets never cross a row end, so the row ends exactly here or not at all
					if (ncol == rw_q) begin
						col_d = '0;
						row_d = row_q + 16'd1;
						if (row_q + 16'd1 == height_q) begin
							phase_d = PH_H0;
						end
					end else begin
						col_d = ncol;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_H0;
			height_q <= '0;
			rw_q     <= '0;
			row_q    <= '0;
			col_q    <= '0;
			rem_q    <= '0;
			run_q    <= 1'b0;
			low_q    <= '0;
			stop_q   <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			height_q <= height_d;
			rw_q     <= rw_d;
			row_q    <= row_d;
			col_q    <= col_d;
			rem_q    <= rem_d;
			run_q    <= run_d;
			low_q    <= low_d;
			stop_q   <= stop_d;
		end
	end

endmodule

>>> src/drbd_cmd_q.sv
module drbd_cmd_q (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  drbd_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output drbd_pkg::cmd_t head
);
	import drbd_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign full       = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> src/drbd_back.sv
module drbd_back #(
	parameter int MAX_ROW_WORDS = drbd_pkg::MAX_ROW_WORDS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_valid,
	input  drbd_pkg::cmd_t head,
	output logic           pop,
	output logic           result_valid,
	input  logic           result_ready,
	output logic [1:0]     kind,
	output logic [15:0]    word_a,
	output logic [15:0]    word_b,
	output logic [1:0]     word_count,
	output logic [15:0]    row_index,
	output logic [5:0]     column_index,
	output logic           last_of_burst,
	output logic           last_of_row,
	output logic           last_of_image,
	output logic [1:0]     error_code
);
	import drbd_pkg::*;

	localparam int COL_W = $clog2(MAX_ROW_WORDS + 1);
	localparam int IDX_W = (MAX_ROW_WORDS > 1) ? $clog2(MAX_ROW_WORDS) : 1;

	logic [15:0]      mem [MAX_ROW_WORDS];
	logic [15:0]      rd_q;

	logic [COL_W-1:0] rw_q;
	logic [15:0]      height_q;
	logic [15:0]      row_q;
	logic [COL_W-1:0] col_q;
	logic             first_q;
	logic [15:0]      even_q;
	logic [6:0]       used_q;

	logic             ov_q;
	res_kind_t        kind_q;
	logic [15:0]      a_q, b_q, row_out_q;
	logic [1:0]       cnt_out_q;
	logic [5:0]       col_out_q;
	logic             lob_q, lrow_q, limg_q;
	err_code_t        err_q;

	logic             go;
	logic             is_word;
	logic [15:0]      old_w, new_w;
	logic [COL_W:0]   c1, c2;
	logic             lrow, limg, next_emit, emit;
	logic [6:0]       left;
	logic             lob;
	logic [COL_W-1:0] col_nx;
	logic [IDX_W-1:0] waddr, raddr;

	res_kind_t        r_kind;
	logic [15:0]      r_a, r_b, r_row;
	logic [1:0]       r_cnt;
	logic [5:0]       r_col;
	logic             r_lrow, r_limg;
	err_code_t        r_err;

	assign go      = head_valid && (!ov_q || result_ready);
	assign is_word = (head.kind == CMD_WORD);

	always_comb begin
		// row 0 of an image sees a cleared line store
		old_w     = first_q ? 16'd0 : rd_q;
		new_w     = old_w ^ head.data_a;
		c1        = {1'b0, col_q} + 1'b1;
		c2        = {1'b0, col_q} + 2'd2;
		lrow      = (c1 == {1'b0, rw_q});
		limg      = lrow && ((17'(row_q) + 17'd1) == 17'(height_q));
		left      = head.count - used_q - 7'd1;
		next_emit = !col_q[0] || (c2 == {1'b0, rw_q});
		lob       = (left == 7'd0) || ((left == 7'd1) && !next_emit);
		emit      = !is_word || col_q[0] || lrow;
		pop       = go && (!is_word || (left == 7'd0));

		col_nx = col_q;
		if (go) begin
			case (head.kind)
				CMD_HDR:  col_nx = '0;
				CMD_WORD: col_nx = lrow ? '0 : COL_W'(c1);
				default:  col_nx = col_q;
			endcase
		end
		waddr = col_q[IDX_W-1:0];
		raddr = col_nx[IDX_W-1:0];

		r_kind = RES_PIXELS;
		r_a    = '0;
		r_b    = '0;
		r_cnt  = 2'd0;
		r_row  = '0;
		r_col  = '0;
		r_lrow = 1'b0;
		r_limg = 1'b0;
		r_err  = ERR_NONE;
		case (head.kind)
			CMD_HDR: begin
				r_kind = RES_HEADER;
				r_a    = head.data_a;
				r_b    = head.data_b;
				r_limg = head.empty_img;
			end
			CMD_ERR: begin
				r_kind = RES_ERROR;
				r_row  = head.data_a;
				r_col  = head.column;
				r_err  = head.err_code;
			end
			default: begin
				r_row  = row_q;
				r_lrow = lrow;
				r_limg = limg;
				if (col_q[0]) begin
					r_a   = even_q;
					r_b   = new_w;
					r_cnt = 2'd2;
					r_col = 6'(col_q - COL_W'(1));
				end else begin
					r_a   = new_w;
					r_cnt = 2'd1;
					r_col = 6'(col_q);
				end
			end
		endcase
	end

	// line store, read one column ahead of the write
	always_ff @(posedge clk) begin
		if (go && is_word) begin
			mem[waddr] <= new_w;
		end
		if (go && is_word && (waddr == raddr)) begin
			rd_q <= new_w;
		end else begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			kind_q    <= r_kind;
			a_q       <= r_a;
			b_q       <= r_b;
			cnt_out_q <= r_cnt;
			row_out_q <= r_row;
			col_out_q <= r_col;
			lob_q     <= is_word ? lob : 1'b1;
			lrow_q    <= r_lrow;
			limg_q    <= r_limg;
			err_q     <= r_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q     <= 1'b0;
			rw_q     <= '0;
			height_q <= '0;
			row_q    <= '0;
			col_q    <= '0;
			first_q  <= 1'b1;
			even_q   <= '0;
			used_q   <= '0;
		end else begin
			if (go && emit) begin
				ov_q <= 1'b1;
			end else if (result_ready) begin
				ov_q <= 1'b0;
			end
			col_q <= col_nx;
			if (go) begin
				case (head.kind)
					CMD_HDR: begin
						rw_q     <= COL_W'(head.data_b);
						height_q <= head.data_a;
						row_q    <= '0;
						first_q  <= 1'b1;
						used_q   <= '0;
					end
					CMD_WORD: begin
						if (!col_q[0]) begin
							even_q <= new_w;
						end
						used_q <= (left == 7'd0) ? 7'd0 : used_q + 7'd1;
						if (lrow) begin
							row_q   <= row_q + 16'd1;
							first_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	assign result_valid  = ov_q;
	assign kind          = kind_q;
	assign word_a        = a_q;
	assign word_b        = b_q;
	assign word_count    = cnt_out_q;
	assign row_index     = row_out_q;
	assign column_index  = col_out_q;
	assign last_of_burst = lob_q;
	assign last_of_row   = lrow_q;
	assign last_of_image = limg_q;
	assign error_code    = err_q;

endmodule

>>> src/delta_row_rle_bitmap_decoder.sv
// Each result is registered in the back end after its command passes the command queue.
// Throughput: one byte per cycle while the 4-entry command queue has room; a run packet
// is written one line-store word per cycle while output is taken; a full queue stalls input.
// Reset (arst_n low, asynchronous) clears parser, queue and output control; the line store
// is not cleared, the first row after each header reads it as zero.
`include "delta_row_rle_bitmap_decoder_assert.svh"

module delta_row_rle_bitmap_decoder #(
	parameter int MAX_ROW_WORDS = drbd_pkg::MAX_ROW_WORDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  stream_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [1:0]  kind,
	output logic [15:0] word_a,
	output logic [15:0] word_b,
	output logic [1:0]  word_count,
	output logic [15:0] row_index,
	output logic [5:0]  column_index,
	output logic        last_of_burst,
	output logic        last_of_row,
	output logic        last_of_image,
	output logic [1:0]  error_code
);
	import drbd_pkg::*;

	logic q_push, q_full, q_pop, q_valid;
	cmd_t q_data, q_head;

	drbd_front #(.MAX_ROW_WORDS(MAX_ROW_WORDS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_ready  (byte_ready),
		.stream_byte (stream_byte),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_data)
	);

	drbd_cmd_q u_cmd_q (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	drbd_back #(.MAX_ROW_WORDS(MAX_ROW_WORDS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (q_valid),
		.head          (q_head),
		.pop           (q_pop),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.kind          (kind),
		.word_a        (word_a),
		.word_b        (word_b),
		.word_count    (word_count),
		.row_index     (row_index),
		.column_index  (column_index),
		.last_of_burst (last_of_burst),
		.last_of_row   (last_of_row),
		.last_of_image (last_of_image),
		.error_code    (error_code)
	);

	`DRBD_ASSERT_IMP(a_no_push_full, q_push, !q_full)
	`DRBD_ASSERT_IMP(a_pair_even, result_valid && kind == RES_PIXELS && word_count == 2'd2,
		!column_index[0])
	`DRBD_ASSERT_IMP(a_img_ends_row, result_valid && kind == RES_PIXELS && last_of_image,
		last_of_row)
	`DRBD_ASSERT_NXT(a_quiet_after_err, result_valid && result_ready && kind == RES_ERROR,
		!result_valid)

endmodule
